// ===== hdl/bccm_pkg.sv =====
package bccm_pkg;

    localparam int AMT_W   = 10;
    localparam int LIMIT_W = 8;
    localparam int CNT_W   = 11;
    localparam int DEPTH   = 1024;

    localparam logic [AMT_W-1:0] MAX_AMOUNT = AMT_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] NO_WAY     = '1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_BEST,
        S_LD_BEST,
        S_STEP,
        S_WR,
        S_RD_TGT,
        S_RES
    } t_state;

endpackage

// ===== hdl/bccm_coin_if.sv =====
interface bccm_coin_if import bccm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [AMT_W-1:0]   coin_value;
    logic [LIMIT_W-1:0] coin_limit;
    logic               last_coin;

    modport source (output valid, output coin_value, output coin_limit, output last_coin,
                    input ready);
    modport sink   (input valid, input coin_value, input coin_limit, input last_coin,
                    output ready);
endinterface

// ===== hdl/bccm_res_if.sv =====
interface bccm_res_if import bccm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [AMT_W-1:0] min_coins;
    logic             reachable;

    modport source (output valid, output min_coins, output reachable, input ready);
    modport sink   (input valid, input min_coins, input reachable, output ready);
endinterface

// ===== hdl/bccm_cfg_if.sv =====
interface bccm_cfg_if import bccm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [AMT_W-1:0] target_amount;

    modport source (output valid, output target_amount, input ready);
    modport sink   (input valid, input target_amount, output ready);
endinterface

// ===== hdl/bounded_coin_change_min.sv =====
// Channel   Direction  Payload                               Handshake
// i_coin    in         coin_value, coin_limit, last_coin     valid/ready
// i_cfg     in         target_amount                         valid/ready, always ready
// o_res     out        min_coins, reachable                  valid/ready
//
// A coin with a zero value or zero limit is taken in S_IDLE alone; otherwise the block walks
// every amount from 1023 down to coin_value through S_RD_BEST, S_LD_BEST, S_STEP and S_WR,
// trying up to min(coin_limit, amount / coin_value) copies of the coin, one per step, paced
// by the single read port of the table, which is read once per step.
// After the last coin of a problem the block reads the target (S_RD_TGT, S_RES) and clears all
// 1024 table entries; the same clearing pass runs after reset, with the coin channel held off.
// A result waiting in the output register stalls the block only when the next result is due.
module bounded_coin_change_min import bccm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bccm_coin_if.sink    i_coin,
    bccm_cfg_if.sink     i_cfg,
    bccm_res_if.source   o_res
);

    t_state             r_state, n_state;
    logic [AMT_W-1:0]   r_clr, n_clr;
    logic [AMT_W-1:0]   r_target;
    logic               r_out_valid, n_out_valid;
    logic [AMT_W-1:0]   r_out_min, n_out_min;
    logic               r_out_reach, n_out_reach;

    logic [AMT_W-1:0]   r_value, n_value;
    logic [LIMIT_W-1:0] r_limit, n_limit;
    logic               r_last, n_last;
    logic [AMT_W-1:0]   r_amt, n_amt;
    logic [CNT_W-1:0]   r_best, n_best;
    logic [LIMIT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0]   r_used, n_used;

    logic [CNT_W-1:0]   r_table [DEPTH];
    logic [CNT_W-1:0]   r_rdata;

    logic               mem_we;
    logic [AMT_W-1:0]   mem_waddr;
    logic [CNT_W-1:0]   mem_wdata;
    logic [AMT_W-1:0]   mem_raddr;

    logic [CNT_W-1:0]   cand;
    logic [CNT_W-1:0]   nxt_used;
    logic [CNT_W-1:0]   diff;

    assign i_coin.ready   = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_res.valid    = r_out_valid;
    assign o_res.min_coins = r_out_min;
    assign o_res.reachable = r_out_reach;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_table[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_target <= i_cfg.target_amount;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_min   <= n_out_min;
        r_out_reach <= n_out_reach;
        r_value     <= n_value;
        r_limit     <= n_limit;
        r_last      <= n_last;
        r_amt       <= n_amt;
        r_best      <= n_best;
        r_k         <= n_k;
        r_used      <= n_used;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_min   = r_out_min;
        n_out_reach = r_out_reach;
        n_value     = r_value;
        n_limit     = r_limit;
        n_last      = r_last;
        n_amt       = r_amt;
        n_best      = r_best;
        n_k         = r_k;
        n_used      = r_used;
        mem_we      = 1'b0;
        mem_waddr   = r_amt;
        mem_wdata   = r_best;
        mem_raddr   = r_amt;
        cand        = r_rdata + CNT_W'(r_k);
        nxt_used    = r_used + CNT_W'(r_value);
        diff        = CNT_W'(r_amt) - nxt_used;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = (r_clr == '0) ? '0 : NO_WAY;
                n_clr     = r_clr + 1'b1;
                if (r_clr == MAX_AMOUNT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_coin.valid) begin
                    n_value = i_coin.coin_value;
                    n_limit = i_coin.coin_limit;
                    n_last  = i_coin.last_coin;
                    n_amt   = MAX_AMOUNT;
                    if (i_coin.coin_value == '0 || i_coin.coin_limit == '0) begin
                        n_state = i_coin.last_coin ? S_RD_TGT : S_IDLE;
                    end else begin
                        n_state = S_RD_BEST;
                    end
                end
            end
            S_RD_BEST: begin
                mem_raddr = r_amt;
                n_state   = S_LD_BEST;
            end
            S_LD_BEST: begin
                n_best    = r_rdata;
                mem_raddr = r_amt - r_value;
                n_k       = LIMIT_W'(1);
                n_used    = CNT_W'(r_value);
                n_state   = S_STEP;
            end
            S_STEP: begin
                if (r_rdata != NO_WAY && cand < r_best) begin
                    n_best = cand;
                end
                if (r_k < r_limit && nxt_used <= CNT_W'(r_amt)) begin
                    mem_raddr = diff[AMT_W-1:0];
                    n_k       = r_k + 1'b1;
                    n_used    = nxt_used;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_amt;
                mem_wdata = r_best;
                n_amt     = r_amt - 1'b1;
                if (r_amt == r_value) begin
                    n_state = r_last ? S_RD_TGT : S_IDLE;
                end else begin
                    n_state = S_RD_BEST;
                end
            end
            S_RD_TGT: begin
                mem_raddr = r_target;
                n_state   = S_RES;
            end
            S_RES: begin
                mem_raddr = r_target;
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    if (r_rdata == NO_WAY) begin
                        n_out_min   = '0;
                        n_out_reach = 1'b0;
                    end else begin
                        n_out_min   = r_rdata[AMT_W-1:0];
                        n_out_reach = 1'b1;
                    end
                    n_clr   = '0;
                    n_state = S_CLEAR;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

endmodule

// ===== hdl/bccm_checker.sv =====
module bccm_checker import bccm_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [AMT_W-1:0] i_min_coins,
    input logic             i_reachable
);

    a_busy_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !i_in_ready)
        else $error("coin channel ready while a new result is raised");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_in_ready)
        else $error("coin channel ready before the table is cleared");

    a_unreachable_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_reachable |-> i_min_coins == '0)
        else $error("unreachable result with a non-zero count");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_min_coins)
            && $stable(i_reachable))
        else $error("stalled result changed");

endmodule

bind bounded_coin_change_min bccm_checker u_bccm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_coin.valid),
    .i_in_ready  (i_coin.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_min_coins (o_res.min_coins),
    .i_reachable (o_res.reachable)
);
